>>> design/ar_archive_member_deframer_macros.svh
// Assertion helpers shared by the deframer RTL.
// Each expects clk and rst_n in scope.
`ifndef AR_ARCHIVE_MEMBER_DEFRAMER_MACROS_SVH
`define AR_ARCHIVE_MEMBER_DEFRAMER_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define AR_AMD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define AR_AMD_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> design/ar_amd_pkg.sv
// ----------------------------------------------------------------------------
// ar_amd_pkg
// Types, constants and helpers of the ar archive member deframer.
// ----------------------------------------------------------------------------
package ar_amd_pkg;

  localparam int NAME_BYTES   = 16;
  localparam int SIZE_DIGITS  = 10;
  localparam int HEADER_BYTES = 60;
  localparam int MAGIC_BYTES  = 8;
  localparam int SIZE_AT      = 48;

  localparam logic [5:0] NAME_END    = 6'(NAME_BYTES);
  localparam logic [5:0] SIZE_START  = 6'(SIZE_AT);
  localparam logic [5:0] SIZE_END    = 6'(SIZE_AT + SIZE_DIGITS);
  localparam logic [5:0] TRAILER_AT  = 6'(HEADER_BYTES - 2);
  localparam logic [5:0] HEADER_LAST = 6'(HEADER_BYTES - 1);
  localparam logic [5:0] MAGIC_LAST  = 6'(MAGIC_BYTES - 1);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] TRAILER_0 = 8'h60;
  localparam logic [7:0] TRAILER_1 = 8'h0A;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER,
    EV_PAYLOAD,
    EV_BAD_MAGIC,
    EV_END
  } event_t;

  typedef enum logic [1:0] {
    KIND_REGULAR,
    KIND_SYMBOL_INDEX,
    KIND_NAME_TABLE,
    KIND_NAME_REF
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  member_kind;
    logic [31:0] payload_offset;
    logic [33:0] body_size;
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [31:0] long_name_offset;
    logic        long_name_valid;
    logic [7:0]  payload_data;
    logic        member_last;
    logic        end_truncated;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } outq_push_t;

  typedef struct packed {
    logic room;
  } outq_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> design/ar_amd_outq.sv
// ----------------------------------------------------------------------------
// ar_amd_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`include "ar_archive_member_deframer_macros.svh"

module ar_amd_outq import ar_amd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  outq_push_t push,
  output outq_stat_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  out_item_t            entry_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   head_r, head_nxt;
  logic [OUTQ_AW-1:0]   tail_r, tail_nxt;
  logic [OUTQ_CW-1:0]   count_r, count_nxt;
  logic [OUTQ_AW-1:0]   tail_plus1;
  logic                 pop;

  assign out_valid     = (count_r != '0);
  assign out_item      = entry_r[head_r];
  assign pop           = out_valid && !out_stall;
  assign status.room   = (count_r <= OUTQ_CW'(OUTQ_DEPTH - 2));
  assign tail_plus1    = tail_r + OUTQ_AW'(1);

  always_comb begin
    head_nxt  = pop ? head_r + OUTQ_AW'(1) : head_r;
    tail_nxt  = tail_r + OUTQ_AW'(push.count);
    count_nxt = OUTQ_CW'(count_r + OUTQ_CW'(push.count) - OUTQ_CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entries carry no reset: only counted entries are ever read.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[tail_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry_r[tail_plus1] <= push.second;
    end
  end

  `AR_AMD_NEVER(a_outq_overflow, count_r > OUTQ_CW'(OUTQ_DEPTH), "result queue overflow")
  `AR_AMD_ASSERT(a_outq_push_room, (push.count != 2'd0) |-> status.room, "push without room")
  `AR_AMD_ASSERT(a_outq_drain, (pop && push.count == 2'd0) |=> (count_r == $past(count_r) - OUTQ_CW'(1)), "pop did not drain")

endmodule

>>> design/ar_archive_member_deframer.sv
// ----------------------------------------------------------------------------
// ar_archive_member_deframer
// Splits a Unix ar archive byte stream into member descriptors and payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one archive byte per transfer (data_byte, last). last marks the
//           final byte; the block then returns to its start state.
//   out_* : results. Each completed 60-byte header yields a member header
//           (or bad-magic) result, each payload byte of a regular or name-reference
//           member a payload result, and the last byte an archive-end result after
//           any other result of that byte. run_last marks the final result
//           of one input byte.
//   Timing: a result is registered in the queue and shown on out_valid in the
//   cycle after its byte's transfer, later only while older results still wait.
//   Throughput: one byte per cycle while in_stall is low; header parsing is
//   done per byte as it arrives, so the header-end byte is taken like any other.
//   Results go through a four-entry queue; in_stall rises when fewer than
//   two entries are free, so a stalled receiver backs up the input once
//   three results wait, and at most four are ever held. Nothing is dropped.
//   Reset (rst_n low, synchronous) clears the parse state but the name
//   registers, and the queue; no clearing pass is needed, the name registers
//   are rewritten by every header before they are read.
// ----------------------------------------------------------------------------
`include "ar_archive_member_deframer_macros.svh"

module ar_archive_member_deframer import ar_amd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Parse state
  phase_t      phase_r, phase_nxt, phase_step;
  logic [5:0]  bpos_r, bpos_nxt, bpos_step;
  logic [31:0] aoff_r, aoff_nxt, aoff_inc;
  logic [33:0] prem_r, prem_nxt, prem_dec;
  logic [33:0] sacc_r, sacc_nxt, sacc_step;
  logic        sdone_r, sdone_nxt;
  logic [31:0] lacc_r, lacc_nxt, lacc_sat;
  logic [35:0] lacc_mul;
  logic        lrun_r, lrun_nxt;
  logic        tok_r, tok_nxt;
  logic [33:0] tsize_r, tsize_nxt;
  logic        tseen_r, tseen_nxt;
  kind_t       kind_r, kind_nxt, hdr_kind;
  logic        pad_r, pad_nxt;
  logic        cut_r, cut_nxt, cut_now;
  logic        n0_slash_r, n0_slash_nxt;
  logic        n1_slash_r, n1_slash_nxt;
  logic        n1_space_r, n1_space_nxt;
  logic        n1_digit_r, n1_digit_nxt;

  // Trimmed short name, one byte register per position
  logic [7:0]  name_r [NAME_BYTES];
  logic [63:0] name_lo, name_hi;

  // Per-byte decode
  logic [7:0]  b;
  logic        in_fire;
  logic        in_name, in_size, at_trail0, at_hdr_end;
  logic        b_digit, b_sep;
  logic        magic_ok;
  logic        hdr_end, pay_byte, trunc;

  // Results
  out_item_t   main_res, end_res;
  logic        main_valid;
  outq_push_t  push;
  outq_stat_t  q_status;

  assign b        = in_item.data_byte;
  assign in_stall = !q_status.room;
  assign in_fire  = in_valid && !in_stall;

  assign in_name    = (bpos_r < NAME_END);
  assign in_size    = (bpos_r >= SIZE_START) && (bpos_r < SIZE_END);
  assign at_trail0  = (bpos_r == TRAILER_AT);
  assign at_hdr_end = (bpos_r >= HEADER_LAST);
  assign b_digit    = is_digit(b);
  assign b_sep      = (b == CH_SLASH) || (b == CH_SPACE);
  assign cut_now    = b_sep || ((bpos_r != 6'd0) && cut_r);
  // Trailer first byte was latched one byte earlier
  assign magic_ok   = tok_r && (b == TRAILER_1);

  assign hdr_end  = (phase_r == PH_HEADER) && at_hdr_end;
  assign pay_byte = (phase_r == PH_PAYLOAD);

  assign aoff_inc  = (aoff_r == SAT32) ? aoff_r : aoff_r + 32'd1;
  assign prem_dec  = prem_r - 34'd1;
  assign sacc_step = 34'(sacc_r * 34'd10 + {30'd0, b[3:0]});
  assign lacc_mul  = {4'd0, lacc_r} * 36'd10 + {32'd0, b[3:0]};
  assign lacc_sat  = (lacc_mul > {4'd0, SAT32}) ? SAT32 : lacc_mul[31:0];

  always_comb begin
    if (n0_slash_r && n1_slash_r) begin
      hdr_kind = KIND_NAME_TABLE;
    end else if (n0_slash_r && n1_space_r) begin
      hdr_kind = KIND_SYMBOL_INDEX;
    end else if (n0_slash_r && n1_digit_r) begin
      hdr_kind = KIND_NAME_REF;
    end else begin
      hdr_kind = KIND_REGULAR;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      name_lo[8*i +: 8] = name_r[i];
      name_hi[8*i +: 8] = name_r[i+8];
    end
  end

  // Next phase and byte position
  always_comb begin
    phase_step = phase_r;
    bpos_step  = bpos_r;
    case (phase_r)
      PH_MAGIC: begin
        if (bpos_r >= MAGIC_LAST) begin
          phase_step = PH_HEADER;
          bpos_step  = 6'd0;
        end else begin
          bpos_step = bpos_r + 6'd1;
        end
      end
      PH_HEADER: begin
        if (at_hdr_end) begin
          bpos_step = 6'd0;
          if (!magic_ok) begin
            phase_step = PH_STOP;
          end else if (sacc_r != 34'd0) begin
            phase_step = PH_PAYLOAD;
          end else begin
            phase_step = PH_HEADER;
          end
        end else begin
          bpos_step = bpos_r + 6'd1;
        end
      end
      PH_PAYLOAD: begin
        if (prem_dec == 34'd0) begin
          phase_step = pad_r ? PH_PAD : PH_HEADER;
        end
      end
      PH_PAD: begin
        phase_step = PH_HEADER;
      end
      PH_STOP: begin
        phase_step = PH_STOP;
      end
      default: begin
        phase_step = PH_MAGIC;
      end
    endcase

    phase_nxt = phase_r;
    bpos_nxt  = bpos_r;
    if (in_fire) begin
      phase_nxt = in_item.last ? PH_MAGIC : phase_step;
      bpos_nxt  = in_item.last ? 6'd0 : bpos_step;
    end
  end

  // Archive ends inside the magic, a header or owed payload
  assign trunc = (phase_step == PH_MAGIC) || (phase_step == PH_PAYLOAD) ||
                 ((phase_step == PH_HEADER) && (bpos_step != 6'd0));

  // Datapath registers
  always_comb begin
    aoff_nxt     = aoff_r;
    prem_nxt     = prem_r;
    sacc_nxt     = sacc_r;
    sdone_nxt    = sdone_r;
    lacc_nxt     = lacc_r;
    lrun_nxt     = lrun_r;
    tok_nxt      = tok_r;
    tsize_nxt    = tsize_r;
    tseen_nxt    = tseen_r;
    kind_nxt     = kind_r;
    pad_nxt      = pad_r;
    cut_nxt      = cut_r;
    n0_slash_nxt = n0_slash_r;
    n1_slash_nxt = n1_slash_r;
    n1_space_nxt = n1_space_r;
    n1_digit_nxt = n1_digit_r;

    if (in_fire) begin
      aoff_nxt = aoff_inc;

      if (phase_r == PH_HEADER) begin
        if (in_name) begin
          cut_nxt = cut_now;
          if (bpos_r == 6'd0) begin
            n0_slash_nxt = (b == CH_SLASH);
            lrun_nxt     = (b == CH_SLASH);
            lacc_nxt     = 32'd0;
          end else if (lrun_r && b_digit) begin
            lacc_nxt = lacc_sat;
          end else begin
            lrun_nxt = 1'b0;
          end
          if (bpos_r == 6'd1) begin
            n1_slash_nxt = (b == CH_SLASH);
            n1_space_nxt = (b == CH_SPACE);
            n1_digit_nxt = b_digit;
          end
        end else if (in_size) begin
          if (!sdone_r) begin
            if (b_digit) begin
              sacc_nxt = sacc_step;
            end else begin
              sdone_nxt = 1'b1;
            end
          end
        end else if (at_trail0) begin
          tok_nxt = (b == TRAILER_0);
        end

        if (at_hdr_end && magic_ok) begin
          if (hdr_kind == KIND_NAME_TABLE) begin
            tsize_nxt = sacc_r;
            tseen_nxt = 1'b1;
          end
          kind_nxt  = hdr_kind;
          prem_nxt  = sacc_r;
          pad_nxt   = sacc_r[0];
          sacc_nxt  = 34'd0;
          sdone_nxt = 1'b0;
          tok_nxt   = 1'b1;
        end
      end

      if (pay_byte) begin
        prem_nxt = prem_dec;
      end

      // Archive end: back to the start state
      if (in_item.last) begin
        aoff_nxt  = 32'd0;
        prem_nxt  = 34'd0;
        sacc_nxt  = 34'd0;
        sdone_nxt = 1'b0;
        lacc_nxt  = 32'd0;
        tok_nxt   = 1'b1;
        tsize_nxt = 34'd0;
        tseen_nxt = 1'b0;
        kind_nxt  = KIND_REGULAR;
        pad_nxt   = 1'b0;
      end
    end
  end

  // Result assembly
  always_comb begin
    main_res   = '0;
    main_valid = 1'b0;
    if (in_fire && hdr_end) begin
      main_valid = 1'b1;
      if (!magic_ok) begin
        main_res.event_res = EV_BAD_MAGIC;
      end else begin
        main_res.event_res      = EV_HEADER;
        main_res.member_kind    = hdr_kind;
        main_res.payload_offset = aoff_inc;
        main_res.body_size      = sacc_r;
        main_res.name_low       = name_lo;
        main_res.name_high      = name_hi;
        main_res.member_last    = (sacc_r == 34'd0);
        if (hdr_kind == KIND_NAME_REF) begin
          main_res.long_name_offset = lacc_r;
          main_res.long_name_valid  = tseen_r && ({2'd0, lacc_r} < tsize_r);
        end
      end
    end else if (in_fire && pay_byte &&
                 (kind_r == KIND_REGULAR || kind_r == KIND_NAME_REF)) begin
      main_valid            = 1'b1;
      main_res.event_res    = EV_PAYLOAD;
      main_res.payload_data = b;
      main_res.member_last  = (prem_dec == 34'd0);
    end
    main_res.run_last = !in_item.last;

    end_res               = '0;
    end_res.event_res     = EV_END;
    end_res.end_truncated = trunc;
    end_res.run_last      = 1'b1;

    push.count  = 2'd0;
    push.first  = main_valid ? main_res : end_res;
    push.second = end_res;
    if (in_fire) begin
      push.count = 2'({1'b0, main_valid} + {1'b0, in_item.last});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC;
      bpos_r     <= 6'd0;
      aoff_r     <= 32'd0;
      prem_r     <= 34'd0;
      sacc_r     <= 34'd0;
      sdone_r    <= 1'b0;
      lacc_r     <= 32'd0;
      lrun_r     <= 1'b0;
      tok_r      <= 1'b1;
      tsize_r    <= 34'd0;
      tseen_r    <= 1'b0;
      kind_r     <= KIND_REGULAR;
      pad_r      <= 1'b0;
      cut_r      <= 1'b0;
      n0_slash_r <= 1'b0;
      n1_slash_r <= 1'b0;
      n1_space_r <= 1'b0;
      n1_digit_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      bpos_r     <= bpos_nxt;
      aoff_r     <= aoff_nxt;
      prem_r     <= prem_nxt;
      sacc_r     <= sacc_nxt;
      sdone_r    <= sdone_nxt;
      lacc_r     <= lacc_nxt;
      lrun_r     <= lrun_nxt;
      tok_r      <= tok_nxt;
      tsize_r    <= tsize_nxt;
      tseen_r    <= tseen_nxt;
      kind_r     <= kind_nxt;
      pad_r      <= pad_nxt;
      cut_r      <= cut_nxt;
      n0_slash_r <= n0_slash_nxt;
      n1_slash_r <= n1_slash_nxt;
      n1_space_r <= n1_space_nxt;
      n1_digit_r <= n1_digit_nxt;
    end
  end

  // Store name bytes, zeroed from the first slash or space on
  always_ff @(posedge clk) begin
    if (in_fire && (phase_r == PH_HEADER) && in_name) begin
      name_r[bpos_r[3:0]] <= cut_now ? 8'd0 : b;
    end
  end

  ar_amd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .status    (q_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `AR_AMD_ASSERT(a_payload_owed, (phase_r == PH_PAYLOAD) |-> (prem_r != 34'd0), "payload phase with nothing owed")
  `AR_AMD_ASSERT(a_header_pos, (phase_r == PH_HEADER) |-> (bpos_r <= HEADER_LAST), "header position past end")
  `AR_AMD_ASSERT(a_magic_only_at_start, (in_fire && !in_item.last) |=> ((phase_r != PH_MAGIC) || ($past(phase_r) == PH_MAGIC)), "magic phase re-entered mid archive")

endmodule

>>> sim/ar_archive_member_deframer_test.sv
// ----------------------------------------------------------------------------
// ar_archive_member_deframer_test
// Streams whole ar archives (well formed, damaged and cut short) through the
// deframer with random idle and stall bursts on both channels. A byte-level
// scoreboard predicts every header, payload, bad-magic and archive-end
// result and checks them in order.
// ----------------------------------------------------------------------------
package ar_amd_tb_pkg;
  import ar_amd_pkg::*;

  localparam logic [7:0] SLASH   = 8'h2F;
  localparam logic [7:0] BLANK   = 8'h20;
  localparam logic [7:0] ZERO_CH = 8'h30;
  localparam logic [7:0] NINE_CH = 8'h39;
  localparam logic [7:0] TICK    = 8'h60;
  localparam logic [7:0] NEWLINE = 8'h0A;

  class ar_event_board;
    // parser state mirrored per accepted byte
    phase_t      phase;
    logic [5:0]  pos;
    logic [31:0] bytes_taken;
    logic [33:0] owed;
    logic [7:0]  names [NAME_BYTES];
    logic [33:0] size_sum;
    bit          size_closed;
    logic [31:0] ref_offset;
    bit          trailer_good;
    logic [33:0] table_len;
    bit          table_known;
    kind_t       body_kind;
    bit          pad_owed;

    out_item_t   pending_events [$];
    int          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase        = PH_MAGIC;
      pos          = '0;
      bytes_taken  = '0;
      owed         = '0;
      foreach (names[i]) names[i] = '0;
      size_sum     = '0;
      size_closed  = 0;
      ref_offset   = '0;
      trailer_good = 1;
      table_len    = '0;
      table_known  = 0;
      body_kind    = KIND_REGULAR;
      pad_owed     = 0;
    endfunction

    function bit decimal(logic [7:0] c);
      return c >= ZERO_CH && c <= NINE_CH;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function out_item_t close_header(bit magic_ok);
      out_item_t   r;
      kind_t       k;
      logic [63:0] wide;
      r = '0;
      pos = '0;
      if (!magic_ok) begin
        r.event_res = EV_BAD_MAGIC;
        phase = PH_STOP;
        return r;
      end
      if (names[0] == SLASH && names[1] == SLASH) k = KIND_NAME_TABLE;
      else if (names[0] == SLASH && names[1] == BLANK) k = KIND_SYMBOL_INDEX;
      else if (names[0] == SLASH && decimal(names[1])) k = KIND_NAME_REF;
      else k = KIND_REGULAR;

      ref_offset = '0;
      if (k == KIND_NAME_REF) begin
        for (int i = 1; i < NAME_BYTES; i++) begin
          if (!decimal(names[i])) break;
          wide = 64'(ref_offset) * 64'd10 + 64'(names[i] - ZERO_CH);
          ref_offset = (wide > 64'(SAT32)) ? SAT32 : wide[31:0];
        end
        r.long_name_offset = ref_offset;
        r.long_name_valid  = table_known && ({2'b00, ref_offset} < table_len);
      end
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (names[i] == SLASH || names[i] == BLANK) break;
        if (i < 8) r.name_low[8*i +: 8] = names[i];
        else r.name_high[8*(i-8) +: 8] = names[i];
      end
      r.event_res      = EV_HEADER;
      r.member_kind    = k;
      r.payload_offset = bytes_taken;
      r.body_size      = size_sum;
      r.member_last    = (size_sum == 0);

      if (k == KIND_NAME_TABLE) begin
        table_len   = size_sum;
        table_known = 1;
      end
      body_kind = k;
      owed      = size_sum;
      pad_owed  = size_sum[0];
      if (owed != 0) phase = PH_PAYLOAD;
      else phase = pad_owed ? PH_PAD : PH_HEADER;
      size_sum     = '0;
      size_closed  = 0;
      trailer_good = 1;
      return r;
    endfunction

    // Work out the results of one accepted archive byte and queue them.
    function void take_byte(in_item_t it);
      out_item_t  step_out [$];
      out_item_t  r;
      logic [7:0] b;
      b = it.data_byte;
      if (bytes_taken != SAT32) bytes_taken++;
      case (phase)
        PH_MAGIC: begin
          pos++;
          if (pos >= MAGIC_BYTES) begin
            phase = PH_HEADER;
            pos = '0;
          end
        end
        PH_HEADER: begin
          if (pos < NAME_BYTES) begin
            names[pos] = b;
          end else if (pos >= SIZE_AT && pos < SIZE_AT + SIZE_DIGITS) begin
            if (!size_closed) begin
              if (decimal(b)) size_sum = size_sum * 34'd10 + 34'(b - ZERO_CH);
              else size_closed = 1;
            end
          end else if (pos == HEADER_BYTES - 2) begin
            trailer_good = (b == TICK);
          end
          if (pos >= HEADER_BYTES - 1) step_out.push_back(close_header(trailer_good && b == NEWLINE));
          else pos++;
        end
        PH_PAYLOAD: begin
          if (owed != 0) owed--;
          if (body_kind == KIND_REGULAR || body_kind == KIND_NAME_REF) begin
            r = '0;
            r.event_res    = EV_PAYLOAD;
            r.payload_data = b;
            r.member_last  = (owed == 0);
            step_out.push_back(r);
          end
          if (owed == 0) phase = pad_owed ? PH_PAD : PH_HEADER;
        end
        PH_PAD: phase = PH_HEADER;
        default: ;
      endcase
      if (it.last) begin
        r = '0;
        r.event_res     = EV_END;
        r.end_truncated = phase == PH_MAGIC || phase == PH_PAYLOAD ||
                          (phase == PH_HEADER && pos != 0);
        step_out.push_back(r);
        restart();
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1;
      foreach (step_out[i]) pending_events.push_back(step_out[i]);
    endfunction

    function string show(out_item_t r);
      return $sformatf({"ev=%0d kind=%0d off=%0d size=%0d name=%h_%h lno=%0d lnv=%0d",
                        " data=%h ml=%0d trunc=%0d rl=%0d"},
                       r.event_res, r.member_kind, r.payload_offset, r.body_size,
                       r.name_high, r.name_low, r.long_name_offset, r.long_name_valid,
                       r.payload_data, r.member_last, r.end_truncated, r.run_last);
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      string     bad;
      if (pending_events.size() == 0) begin
        note_error($sformatf("result with none expected\n  got  %s", show(got)));
        return;
      end
      want = pending_events.pop_front();
      bad = "";
      if (got.event_res !== want.event_res) bad = {bad, " event_res"};
      if (got.member_kind !== want.member_kind) bad = {bad, " member_kind"};
      if (got.payload_offset !== want.payload_offset) bad = {bad, " payload_offset"};
      if (got.body_size !== want.body_size) bad = {bad, " body_size"};
      if (got.name_low !== want.name_low) bad = {bad, " name_low"};
      if (got.name_high !== want.name_high) bad = {bad, " name_high"};
      if (got.long_name_offset !== want.long_name_offset) bad = {bad, " long_name_offset"};
      if (got.long_name_valid !== want.long_name_valid) bad = {bad, " long_name_valid"};
      if (got.payload_data !== want.payload_data) bad = {bad, " payload_data"};
      if (got.member_last !== want.member_last) bad = {bad, " member_last"};
      if (got.end_truncated !== want.end_truncated) bad = {bad, " end_truncated"};
      if (got.run_last !== want.run_last) bad = {bad, " run_last"};
      if (bad != "")
        note_error($sformatf("wrong%s\n  want %s\n  got  %s", bad, show(want), show(got)));
    endfunction
  endclass
endpackage

module ar_archive_member_deframer_test;
  import ar_amd_pkg::*;
  import ar_amd_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT       = 1000000;  // cycles before the run is declared hung
  localparam int LONG_HOLD   = 300;      // receiver hold-off, far beyond the result queue
  localparam int RANDOM_BYTES = 100;     // random section; the directed archives add ~1000

  typedef logic [7:0] name_bytes_t [NAME_BYTES];

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_item;

  ar_event_board board = new();

  // Archive under construction, sent byte by byte with last on the final one.
  logic [7:0] arc_bytes [$];

  // Idle control: odds of a burst (0 = never), per byte sent or per receiver check; calm stops the random bursts.
  int tx_gap_odds = 6;
  int rx_stall_odds = 6;
  bit calm = 0;
  bit hold_request = 0;
  int cycle_count = 0;

  ar_archive_member_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Hang guard: count cycles and give up well past the slowest legal run.
  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_event(out_item);
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // result queue fills and the block has to stall its input.
  initial begin : receiver
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 0;
        hold_request = 0;
      end else if (!calm && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
        out_stall = 1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  // Offer one byte from a falling edge, hold it until the transfer, note it,
  // then drop valid so nothing is offered while the caller waits.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (!calm && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
      in_valid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1;
    in_item.data_byte = b;
    in_item.last = lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(in_item);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic send_archive();
    foreach (arc_bytes[i]) send_byte(arc_bytes[i], i == arc_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic name_bytes_t text_name(string s);
    name_bytes_t nm;
    for (int i = 0; i < NAME_BYTES; i++) nm[i] = (i < s.len()) ? s[i] : BLANK;
    return nm;
  endfunction

  // Random short name: plain letters with a slash or blank end, or raw bytes.
  function automatic name_bytes_t random_name();
    name_bytes_t nm;
    int          len;
    int          style;
    len = $urandom_range(1, NAME_BYTES);
    style = $urandom_range(0, 3);
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (i < len) nm[i] = (style == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(8'h61, 8'h7A));
      else if (i == len && style == 1) nm[i] = SLASH;
      else nm[i] = BLANK;
    end
    return nm;
  endfunction

  function automatic void add_magic(bit proper);
    string m;
    m = "!<arch>\n";
    for (int i = 0; i < MAGIC_BYTES; i++)
      arc_bytes.push_back(proper ? m[i] : 8'($urandom_range(0, 255)));
  endfunction

  // Header with random date/owner/mode bytes, then body bytes and a pad byte for an odd body.
  function automatic void add_member(name_bytes_t nm, string sz, int body, bit good);
    logic [7:0] t0;
    logic [7:0] t1;
    logic [1:0] wrong;
    foreach (nm[i]) arc_bytes.push_back(nm[i]);
    for (int i = NAME_BYTES; i < SIZE_AT; i++) arc_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < SIZE_DIGITS; i++) arc_bytes.push_back((i < sz.len()) ? sz[i] : BLANK);
    t0 = TICK;
    t1 = NEWLINE;
    if (!good) begin
      wrong = 2'($urandom_range(1, 3));
      if (wrong[0]) t0 = TICK ^ 8'($urandom_range(1, 255));
      if (wrong[1]) t1 = NEWLINE ^ 8'($urandom_range(1, 255));
    end
    arc_bytes.push_back(t0);
    arc_bytes.push_back(t1);
    for (int i = 0; i < body + body % 2; i++) arc_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_noise(int count);
    repeat (count) arc_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  // Mostly well-formed archives with random members; some damaged or cut short.
  function automatic void build_random_archive();
    name_bytes_t nm;
    string       sz;
    int          pick;
    int          body;
    bit          stop;
    arc_bytes.delete();
    add_magic($urandom_range(0, 9) != 0);
    stop = 0;
    for (int m = $urandom_range(1, 5); m > 0 && !stop; m--) begin
      pick = $urandom_range(0, 99);
      body = $urandom_range(0, 12);
      if (pick < 50) nm = random_name();
      else if (pick < 60) nm = text_name("/");
      else if (pick < 72) begin
        nm = text_name("//");
        body = $urandom_range(0, 40);
      end else nm = text_name($sformatf("/%0d", $urandom_range(0, 60)));
      sz = $sformatf("%0d", body);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        sz = {sz, "x7"};
        add_member(nm, sz, body, 1);
      end else if (pick < 10) begin
        add_member(nm, {" ", sz}, 0, 1);
      end else if (pick < 14) begin
        // huge size: the archive ends inside the payload unless it is cut shorter below
        sz = $urandom_range(0, 1) ? "9999999999" : $sformatf("%0d", $urandom_range(100, 32'hFFFFFFFF));
        add_member(nm, sz, 0, 1);
        add_noise($urandom_range(0, 20));
        stop = 1;
      end else if (pick < 18) begin
        add_member(nm, sz, 0, 0);
        add_noise($urandom_range(0, 8));
        stop = 1;
      end else begin
        add_member(nm, sz, body, 1);
      end
    end
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(0, arc_bytes.size() - 1)) void'(arc_bytes.pop_back());
  endfunction

  initial begin : main
    int random_sent;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // Directed: archive ending inside the global magic (truncated).
    arc_bytes.delete();
    add_magic(1);
    repeat (5) void'(arc_bytes.pop_back());
    send_archive();

    // Magic alone ends cleanly.
    arc_bytes.delete();
    add_magic(1);
    send_archive();

    // Every member kind, odd sizes with pad, empty member, full-width and
    // blank-cut names, saturating reference, table replaced by a later one.
    arc_bytes.delete();
    add_magic(1);
    add_member(text_name("/5"), "4", 4, 1);                // reference before any table
    add_member(text_name("/"), "7", 7, 1);                 // symbol index, padded
    add_member(text_name("//"), "20", 20, 1);              // long-name table
    add_member(text_name("/0"), "3", 3, 1);                // reference inside table
    add_member(text_name("/20"), "2", 2, 1);               // reference at table size
    add_member(text_name("/999999999999999"), "1", 1, 1);  // offset saturates
    add_member(text_name("empty.o/"), "0", 0, 1);
    add_member(text_name("abcdefghijklmnop"), "2", 2, 1);
    add_member(text_name("ab cd/"), "1z", 1, 1);           // size stops at non-digit
    add_member(text_name("//"), "30", 30, 1);              // table seen again
    add_member(text_name("/20"), "0000000002", 2, 1);      // now inside the table
    // Hold the receiver off while the bytes keep coming: the queue fills
    // and the block stalls its input.
    hold_request = 1;
    send_archive();
    // Pause the sender until every result is in.
    wait_drained();

    // Random archives with idling on both sides.
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      build_random_archive();
      tx_gap_odds = pick_odds();
      rx_stall_odds = pick_odds();
      send_archive();
      random_sent += arc_bytes.size();
    end

    // Last part without any idling.
    calm = 1;

    // Bad trailer magic on the final byte: bad-magic then archive end.
    arc_bytes.delete();
    add_magic(1);
    add_member(text_name("x/"), "0", 0, 0);
    send_archive();

    // Bad trailer magic, then bytes dropped until the last one.
    arc_bytes.delete();
    add_magic(1);
    add_member(text_name("y/"), "3", 3, 0);
    send_archive();

    // Largest size field, archive ends inside the payload.
    arc_bytes.delete();
    add_magic(1);
    add_member(text_name("big/"), "9999999999", 0, 1);
    add_noise(3);
    send_archive();

    // Archive ends inside a header.
    arc_bytes.delete();
    add_magic(0);
    add_member(text_name("h/"), "1", 1, 1);
    repeat (30) void'(arc_bytes.pop_back());
    send_archive();

    // Archive ends on a pad byte.
    arc_bytes.delete();
    add_magic(1);
    add_member(text_name("odd/"), "3", 3, 1);
    send_archive();

    in_valid = 0;
    wait_drained();
    repeat (8) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/ar_amd_pkg.sv
design/ar_amd_outq.sv
design/ar_archive_member_deframer.sv
sim/ar_archive_member_deframer_test.sv
